FILE: rtl/core/pgan_pkg.sv
`timescale 1ns / 1ps

package pgan_pkg;

   localparam int CHANNELS              = 4;
   localparam int FRAMES_PER_PACKET_DEF = 12;

   localparam int DATA_W     = 32;
   localparam int COEF_W     = 32;
   localparam int PKT_W      = 32;
   localparam int GAP_W      = 32;
   localparam int GRID_W     = 48;
   localparam int DELAY_W    = 48;
   localparam int PROD_W     = DATA_W + COEF_W;
   localparam int FRAC_SHIFT = 30;
   localparam int RND_W      = PROD_W - FRAC_SHIFT;
   localparam int Y_SUM_W    = DELAY_W + 1;
   localparam int Z_SUM_W    = DELAY_W + 2;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTCH_ON = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2  = 3'd5;

   localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 32'sh4000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POS,
      ST_CMP,
      ST_YCALC,
      ST_MULA,
      ST_UPD,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   typedef struct packed {
      logic mul1;
      logic mul2;
      logic ycalc;
      logic gap_clear;
      logic mul3;
      logic update;
      logic cfg_clear;
   } lane_ctl_type;

   typedef struct packed {
      logic first_step;
      logic decide;
   } grid_ctl_type;

   typedef struct packed {
      logic              emit;
      logic              clear;
      logic [GAP_W-1:0]  gap;
      logic [GRID_W-1:0] grid_pos;
   } grid_dec_type;

   // round to nearest, ties up, then floor shift by the coefficient fraction
   function automatic logic signed [RND_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] s;
      s = p + (PROD_W'(1) << (FRAC_SHIFT - 1));
      return s[PROD_W-1:FRAC_SHIFT];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [Y_SUM_W-1:0] v);
      logic [Y_SUM_W-DATA_W:0] top;
      top = v[Y_SUM_W-1:DATA_W-1];
      if ((&top) || !(|top)) begin
         return v[DATA_W-1:0];
      end else if (v[Y_SUM_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [Z_SUM_W-1:0] v);
      logic [Z_SUM_W-DELAY_W:0] top;
      top = v[Z_SUM_W-1:DELAY_W-1];
      if ((&top) || !(|top)) begin
         return v[DELAY_W-1:0];
      end else if (v[Z_SUM_W-1]) begin
         return {1'b1, {(DELAY_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DELAY_W-1){1'b1}}};
      end
   endfunction

endpackage

FILE: rtl/core/pgan_grid.sv
`timescale 1ns / 1ps

module pgan_grid
   import pgan_pkg::*;
#(
   parameter int FRAMES_PER_PACKET = FRAMES_PER_PACKET_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  grid_ctl_type      ctl,
   input  logic [PKT_W-1:0]  packet_number,
   input  logic              starts_packet,
   output grid_dec_type      dec
);

   localparam int POS_W = PKT_W + 1 + $clog2(FRAMES_PER_PACKET + 1);
   localparam int CMP_W = (POS_W > GRID_W + 1) ? POS_W : GRID_W + 1;
   localparam logic signed [POS_W-1:0] FPP_S = POS_W'(FRAMES_PER_PACKET);

   logic                     seen_first_ff, seen_first_in;
   logic [PKT_W-1:0]         base_ff, base_in;
   logic [GRID_W-1:0]        grid_ff, grid_in;
   logic                     dropping_ff, dropping_in;
   logic signed [POS_W-1:0]  pos_ff, pos_in;
   grid_dec_type             dec_ff, dec_in;

   logic [PKT_W-1:0]         base_eff;
   logic signed [PKT_W:0]    diff;
   logic signed [CMP_W-1:0]  pos_c;
   logic signed [CMP_W-1:0]  grid_c;
   logic signed [CMP_W-1:0]  gap_full;
   logic                     behind;
   logic                     ahead;

   always_comb begin
      base_eff = seen_first_ff ? base_ff : packet_number;
      diff     = $signed({1'b0, packet_number}) - $signed({1'b0, base_eff});
      pos_in   = POS_W'(diff) * FPP_S;
      pos_c    = CMP_W'(pos_ff);
      grid_c   = CMP_W'($signed({1'b0, grid_ff}));
      behind   = pos_c < grid_c;
      ahead    = pos_c > grid_c;
      gap_full = pos_c - grid_c;
   end

   always_comb begin
      seen_first_in = seen_first_ff;
      base_in       = base_ff;
      grid_in       = grid_ff;
      dropping_in   = dropping_ff;
      dec_in        = dec_ff;
      if (ctl.first_step) begin
         if (starts_packet && !seen_first_ff) begin
            seen_first_in = 1'b1;
            base_in       = packet_number;
            grid_in       = '0;
         end
      end
      if (ctl.decide) begin
         dec_in.emit     = 1'b0;
         dec_in.clear    = 1'b0;
         dec_in.gap      = '0;
         dec_in.grid_pos = grid_ff;
         if (starts_packet) begin
            if (behind) begin
               dropping_in = 1'b1;
            end else begin
               dropping_in = 1'b0;
               dec_in.emit = 1'b1;
               if (ahead) begin
                  dec_in.clear    = 1'b1;
                  dec_in.gap      = (|gap_full[CMP_W-1:GAP_W]) ? '1 : gap_full[GAP_W-1:0];
                  dec_in.grid_pos = pos_c[GRID_W-1:0];
               end
            end
         end else begin
            dec_in.emit = seen_first_ff && !dropping_ff;
         end
         if (dec_in.emit) begin
            grid_in = dec_in.grid_pos + GRID_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_first_ff <= 1'b0;
         base_ff       <= '0;
         grid_ff       <= '0;
         dropping_ff   <= 1'b0;
         dec_ff        <= '0;
      end else begin
         seen_first_ff <= seen_first_in;
         base_ff       <= base_in;
         grid_ff       <= grid_in;
         dropping_ff   <= dropping_in;
         dec_ff        <= dec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.first_step) begin
         pos_ff <= pos_in;
      end
   end

   assign dec = dec_ff;

endmodule

FILE: rtl/core/pgan_lane.sv
`timescale 1ns / 1ps

module pgan_lane
   import pgan_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctl_type             ctl,
   input  coef_type                 coef,
   input  logic                     active,
   input  logic signed [DATA_W-1:0] x,
   output logic signed [DATA_W-1:0] y
);

   logic signed [PROD_W-1:0]  p0_ff, p0_in;
   logic signed [PROD_W-1:0]  p1_ff, p1_in;
   logic signed [PROD_W-1:0]  p2_ff, p2_in;
   logic signed [PROD_W-1:0]  q1_ff, q1_in;
   logic signed [PROD_W-1:0]  q2_ff, q2_in;
   logic signed [DELAY_W-1:0] d1_ff, d1_in;
   logic signed [DELAY_W-1:0] d2_ff, d2_in;
   logic signed [DATA_W-1:0]  y_ff, y_in;
   logic signed [Y_SUM_W-1:0] s1_ff, s1_in;
   logic signed [RND_W-1:0]   s2_ff, s2_in;

   logic signed [DELAY_W-1:0] d1_eff;
   logic signed [DELAY_W-1:0] d2_eff;
   logic signed [Y_SUM_W-1:0] ysum;
   logic signed [Z_SUM_W-1:0] z1;
   logic signed [Z_SUM_W-1:0] z2;

   always_comb begin
      p0_in  = PROD_W'($signed(coef.b0)) * PROD_W'(x);
      p1_in  = PROD_W'($signed(coef.b1)) * PROD_W'(x);
      p2_in  = PROD_W'($signed(coef.b2)) * PROD_W'(x);
      // a packet gap clears the delays before this frame uses them
      d1_eff = ctl.gap_clear ? '0 : d1_ff;
      d2_eff = ctl.gap_clear ? '0 : d2_ff;
      ysum   = Y_SUM_W'(round_q30(p0_ff)) + Y_SUM_W'(d1_eff);
      y_in   = sat_data(ysum);
      s1_in  = Y_SUM_W'(round_q30(p1_ff)) + Y_SUM_W'(d2_eff);
      s2_in  = round_q30(p2_ff);
      q1_in  = PROD_W'($signed(coef.a1)) * PROD_W'(y_ff);
      q2_in  = PROD_W'($signed(coef.a2)) * PROD_W'(y_ff);
      z1     = Z_SUM_W'(s1_ff) - Z_SUM_W'(round_q30(q1_ff));
      z2     = Z_SUM_W'(s2_ff) - Z_SUM_W'(round_q30(q2_ff));
      d1_in  = sat_delay(z1);
      d2_in  = sat_delay(z2);
      y      = active ? y_ff : x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (ctl.cfg_clear || (ctl.ycalc && ctl.gap_clear)) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (ctl.update && active) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul1) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
      end
      if (ctl.mul2) begin
         p2_ff <= p2_in;
      end
      if (ctl.ycalc) begin
         y_ff  <= y_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
      if (ctl.mul3) begin
         q1_ff <= q1_in;
         q2_ff <= q2_in;
      end
   end

endmodule

FILE: rtl/core/pgan_merge.sv
`timescale 1ns / 1ps

module pgan_merge
   import pgan_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic signed [DATA_W-1:0] lane_y [CHANNELS],
   input  logic [CHANNELS-1:0]      mask,
   input  logic [GAP_W-1:0]         gap,
   input  logic [GRID_W-1:0]        grid_pos,
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_filtered [CHANNELS],
   output logic [CHANNELS-1:0]      rsp_absent_out,
   output logic [GAP_W-1:0]         rsp_gap_before,
   output logic [GRID_W-1:0]        rsp_grid_position
);

   logic                     valid_ff;
   logic signed [DATA_W-1:0] filtered_ff [CHANNELS];
   logic [CHANNELS-1:0]      absent_ff;
   logic [GAP_W-1:0]         gap_ff;
   logic [GRID_W-1:0]        grid_pos_ff;

   assign free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int c = 0; c < CHANNELS; c++) begin
            filtered_ff[c] <= lane_y[c];
         end
         absent_ff   <= mask;
         gap_ff      <= gap;
         grid_pos_ff <= grid_pos;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_filtered      = filtered_ff;
   assign rsp_absent_out    = absent_ff;
   assign rsp_gap_before    = gap_ff;
   assign rsp_grid_position = grid_pos_ff;

endmodule

FILE: rtl/core/packet_gap_aligned_notch_filter.sv
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// req      in   req_valid/req_ready  packet_number, starts_packet, sample_ch0..3, absent_mask
// rsp      out  rsp_valid/rsp_ready  filtered_ch0..3, absent_out, gap_before, grid_position
// csr      in   csr_valid/csr_ready  csr_index (0..5), csr_data
//
// an item with a result passes POS, CMP, YCALC, MULA and UPD before the next acceptance,
// set by the lane chain: forward products, y, feedback products, delay update; an item
// without a result returns to idle after YCALC; a waiting result lets the next item in;
// a second finished result holds the block in its write step until the result register frees
// reset is synchronous and holds req_ready and csr_ready low; grid state, delays and
// configuration registers go to their defaults; outside reset a csr write is never held off

module packet_gap_aligned_notch_filter
   import pgan_pkg::*;
#(
   parameter int FRAMES_PER_PACKET = FRAMES_PER_PACKET_DEF
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [PKT_W-1:0]            req_packet_number,
   input  logic                        req_starts_packet,
   input  logic signed [DATA_W-1:0]    req_sample_ch0,
   input  logic signed [DATA_W-1:0]    req_sample_ch1,
   input  logic signed [DATA_W-1:0]    req_sample_ch2,
   input  logic signed [DATA_W-1:0]    req_sample_ch3,
   input  logic [CHANNELS-1:0]         req_absent_mask,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DATA_W-1:0]    rsp_filtered_ch0,
   output logic signed [DATA_W-1:0]    rsp_filtered_ch1,
   output logic signed [DATA_W-1:0]    rsp_filtered_ch2,
   output logic signed [DATA_W-1:0]    rsp_filtered_ch3,
   output logic [CHANNELS-1:0]         rsp_absent_out,
   output logic [GAP_W-1:0]            rsp_gap_before,
   output logic [GRID_W-1:0]           rsp_grid_position,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [COEF_W-1:0]           csr_data
);

   state_type                state_ff, state_in;
   logic [PKT_W-1:0]         pkt_ff;
   logic                     starts_ff;
   logic signed [DATA_W-1:0] x_ff [CHANNELS];
   logic [CHANNELS-1:0]      mask_ff;
   logic                     notch_on_ff;
   coef_type                 coef_ff;

   logic                     cfg_hit;
   logic                     merge_load;
   logic                     merge_free;
   lane_ctl_type             lane_ctl;
   grid_ctl_type             grid_ctl;
   grid_dec_type             grid_dec;
   logic signed [DATA_W-1:0] lane_y [CHANNELS];
   logic signed [DATA_W-1:0] rsp_filtered [CHANNELS];

   // configuration
   assign csr_ready = !reset;

   always_comb begin
      cfg_hit = 1'b0;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NOTCH_ON, CSR_COEF_B0, CSR_COEF_B1,
            CSR_COEF_B2, CSR_COEF_A1, CSR_COEF_A2: cfg_hit = 1'b1;
            default: cfg_hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         notch_on_ff <= 1'b0;
         coef_ff.b0  <= COEF_B0_RESET;
         coef_ff.b1  <= '0;
         coef_ff.b2  <= '0;
         coef_ff.a1  <= '0;
         coef_ff.a2  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NOTCH_ON: notch_on_ff <= csr_data[0];
            CSR_COEF_B0:  coef_ff.b0  <= csr_data;
            CSR_COEF_B1:  coef_ff.b1  <= csr_data;
            CSR_COEF_B2:  coef_ff.b2  <= csr_data;
            CSR_COEF_A1:  coef_ff.a1  <= csr_data;
            CSR_COEF_A2:  coef_ff.a2  <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_POS;
         ST_POS:   state_in = ST_CMP;
         ST_CMP:   state_in = ST_YCALC;
         ST_YCALC: state_in = grid_dec.emit ? ST_MULA : ST_IDLE;
         ST_MULA:  state_in = ST_UPD;
         ST_UPD:   state_in = merge_free ? ST_IDLE : ST_WRITE;
         ST_WRITE: state_in = merge_free ? ST_IDLE : ST_WRITE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready           = (state_ff == ST_IDLE) && !reset;
      grid_ctl.first_step = (state_ff == ST_POS);
      grid_ctl.decide     = (state_ff == ST_CMP);
      lane_ctl.mul1       = (state_ff == ST_POS);
      lane_ctl.mul2       = (state_ff == ST_CMP);
      lane_ctl.ycalc      = (state_ff == ST_YCALC);
      lane_ctl.gap_clear  = (state_ff == ST_YCALC) && grid_dec.clear;
      lane_ctl.mul3       = (state_ff == ST_MULA);
      lane_ctl.update     = (state_ff == ST_UPD);
      lane_ctl.cfg_clear  = cfg_hit;
      merge_load          = ((state_ff == ST_UPD) || (state_ff == ST_WRITE)) && merge_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pkt_ff    <= req_packet_number;
         starts_ff <= req_starts_packet;
         x_ff[0]   <= req_sample_ch0;
         x_ff[1]   <= req_sample_ch1;
         x_ff[2]   <= req_sample_ch2;
         x_ff[3]   <= req_sample_ch3;
         mask_ff   <= req_absent_mask;
      end
   end

   pgan_grid #(
      .FRAMES_PER_PACKET (FRAMES_PER_PACKET)
   ) u_grid (
      .clock         (clock),
      .reset         (reset),
      .ctl           (grid_ctl),
      .packet_number (pkt_ff),
      .starts_packet (starts_ff),
      .dec           (grid_dec)
   );

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      pgan_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .coef   (coef_ff),
         .active (notch_on_ff && !mask_ff[c] && grid_dec.emit),
         .x      (x_ff[c]),
         .y      (lane_y[c])
      );
   end

   pgan_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .load              (merge_load),
      .lane_y            (lane_y),
      .mask              (mask_ff),
      .gap               (grid_dec.gap),
      .grid_pos          (grid_dec.grid_pos),
      .free              (merge_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered      (rsp_filtered),
      .rsp_absent_out    (rsp_absent_out),
      .rsp_gap_before    (rsp_gap_before),
      .rsp_grid_position (rsp_grid_position)
   );

   assign rsp_filtered_ch0 = rsp_filtered[0];
   assign rsp_filtered_ch1 = rsp_filtered[1];
   assign rsp_filtered_ch2 = rsp_filtered[2];
   assign rsp_filtered_ch3 = rsp_filtered[3];

`ifndef ASSERT_OFF
   a_accept_to_pos: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_POS))
      else $error("accepted item did not start the sequence");

   a_mula_needs_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULA) |-> grid_dec.emit)
      else $error("lanes running on an item without a result");

   a_gap_clear_emit: assert property (@(posedge clock) disable iff (reset)
      lane_ctl.gap_clear |-> grid_dec.emit)
      else $error("delays cleared for a dropped item");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(merge_load))
      else $error("result valid without a merge load");
`endif

endmodule

FILE: test/packet_gap_aligned_notch_filter_tb.sv
`timescale 1ns / 1ps

module packet_gap_aligned_notch_filter_tb;
   import pgan_pkg::*;

   localparam int FRAMES        = FRAMES_PER_PACKET_DEF;
   localparam int SETTLE_CYCLES = 12;
   localparam int RUN_LIMIT_NS  = 6_000_000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [DATA_W-1:0] S_MAX  = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] S_MIN  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] S_NEG1 = 32'hFFFF_FFFF;

   // a notch near 0.074 of the sample rate
   localparam logic [COEF_W-1:0] NOTCH_B0 = 32'd1020054733;
   localparam logic [COEF_W-1:0] NOTCH_B1 = -32'sd1825361101;
   localparam logic [COEF_W-1:0] NOTCH_A2 = 32'd966367642;

   localparam longint Y_MAX   = (longint'(1) <<< 31) - 1;
   localparam longint Y_MIN   = -(longint'(1) <<< 31);
   localparam longint DLY_MAX = (longint'(1) <<< 47) - 1;
   localparam longint DLY_MIN = -(longint'(1) <<< 47);
   localparam longint GAP_SAT = 64'sh0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [PKT_W-1:0]                   pkt;
      logic                               sop;
      logic [CHANNELS-1:0][DATA_W-1:0]    smp;
      logic [CHANNELS-1:0]                absent;
   } in_frame_type;

   typedef struct packed {
      logic [CHANNELS-1:0][DATA_W-1:0]    y;
      logic [CHANNELS-1:0]                absent;
      logic [GAP_W-1:0]                   gap;
      logic [GRID_W-1:0]                  grid;
   } out_frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PKT_W-1:0]         req_packet_number = '0;
   logic                     req_starts_packet = 1'b0;
   logic signed [DATA_W-1:0] req_sample_ch0 = '0;
   logic signed [DATA_W-1:0] req_sample_ch1 = '0;
   logic signed [DATA_W-1:0] req_sample_ch2 = '0;
   logic signed [DATA_W-1:0] req_sample_ch3 = '0;
   logic [CHANNELS-1:0]      req_absent_mask = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_filtered_ch0;
   logic signed [DATA_W-1:0] rsp_filtered_ch1;
   logic signed [DATA_W-1:0] rsp_filtered_ch2;
   logic signed [DATA_W-1:0] rsp_filtered_ch3;
   logic [CHANNELS-1:0]      rsp_absent_out;
   logic [GAP_W-1:0]         rsp_gap_before;
   logic [GRID_W-1:0]        rsp_grid_position;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [COEF_W-1:0]        csr_data = '0;

   // predictor copy of the block
   logic              notch_en = 1'b0;
   longint            cb0 = longint'(COEF_B0_RESET);
   longint            cb1 = 0;
   longint            cb2 = 0;
   longint            ca1 = 0;
   longint            ca2 = 0;
   logic              have_base = 1'b0;
   logic [PKT_W-1:0]  base_pkt = '0;
   logic [GRID_W-1:0] grid_len = '0;
   logic              skipping_pkt = 1'b0;
   longint            dly1 [CHANNELS] = '{default: 0};
   longint            dly2 [CHANNELS] = '{default: 0};

   out_frame_type filtered_due [$];
   int         produced = 0;
   int         mismatches = 0;
   logic [PKT_W-1:0] next_pkt = '0;
   bit         steady = 1'b0;
   int         sink_hold = 0;

   packet_gap_aligned_notch_filter DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic longint scale_q30(input longint coef, input longint v);
      return (coef * v + (longint'(1) <<< 29)) >>> 30;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic zero_delays();
      foreach (dly1[c]) begin
         dly1[c] = 0;
         dly2[c] = 0;
      end
   endtask

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      case (idx)
         CSR_NOTCH_ON: notch_en = data[0];
         CSR_COEF_B0: cb0 = $signed(data);
         CSR_COEF_B1: cb1 = $signed(data);
         CSR_COEF_B2: cb2 = $signed(data);
         CSR_COEF_A1: ca1 = $signed(data);
         CSR_COEF_A2: ca2 = $signed(data);
         default: return;
      endcase
      zero_delays();
   endtask

   task automatic filter_frame(input in_frame_type f);
      longint        pos, gap, x, y, z1, z2;
      out_frame_type r;
      r = '0;
      if (f.sop) begin
         if (!have_base) begin
            have_base = 1'b1;
            base_pkt  = f.pkt;
            grid_len  = '0;
         end
         pos = (longint'(f.pkt) - longint'(base_pkt)) * FRAMES;
         if (pos < longint'(grid_len)) begin
            skipping_pkt = 1'b1;
            return;
         end
         skipping_pkt = 1'b0;
         if (pos > longint'(grid_len)) begin
            gap   = pos - longint'(grid_len);
            r.gap = (gap > GAP_SAT) ? 32'hFFFF_FFFF : gap[31:0];
            zero_delays();
            grid_len = pos[GRID_W-1:0];
         end
      end else if (!have_base || skipping_pkt) begin
         return;
      end
      for (int c = 0; c < CHANNELS; c++) begin
         x = $signed(f.smp[c]);
         y = x;
         if (notch_en && !f.absent[c]) begin
            y  = clip(scale_q30(cb0, x) + dly1[c], Y_MIN, Y_MAX);
            z1 = scale_q30(cb1, x) - scale_q30(ca1, y) + dly2[c];
            z2 = scale_q30(cb2, x) - scale_q30(ca2, y);
            dly1[c] = clip(z1, DLY_MIN, DLY_MAX);
            dly2[c] = clip(z2, DLY_MIN, DLY_MAX);
         end
         r.y[c] = y[31:0];
      end
      r.absent = f.absent;
      r.grid   = grid_len;
      grid_len = grid_len + 1'b1;
      filtered_due.push_back(r);
      produced++;
   endtask

   function automatic logic [DATA_W-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      if (r < 60) return $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
      if (r < 85) return $urandom();
      case ($urandom_range(0, 3))
         0: return S_MAX;
         1: return S_MIN;
         2: return '0;
         default: return S_NEG1;
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] rand_coef();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
      return $urandom();
   endfunction

   function automatic in_frame_type build_frame(input logic [PKT_W-1:0] pkt, input logic sop,
         input logic [DATA_W-1:0] s0, s1, s2, s3, input logic [CHANNELS-1:0] mask);
      in_frame_type f;
      f.pkt    = pkt;
      f.sop    = sop;
      f.smp    = {s3, s2, s1, s0};
      f.absent = mask;
      return f;
   endfunction

   function automatic in_frame_type random_frame(input logic [PKT_W-1:0] pkt, input logic sop);
      logic [CHANNELS-1:0] mask;
      mask = ($urandom_range(0, 1) == 0) ? '0 : CHANNELS'($urandom_range(0, 15));
      return build_frame(pkt, sop, rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                         mask);
   endfunction

   task automatic send_frame(input in_frame_type f);
      int pause;
      req_valid         <= 1'b1;
      req_packet_number <= f.pkt;
      req_starts_packet <= f.sop;
      req_sample_ch0    <= f.smp[0];
      req_sample_ch1    <= f.smp[1];
      req_sample_ch2    <= f.smp[2];
      req_sample_ch3    <= f.smp[3];
      req_absent_mask   <= f.absent;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      filter_frame(f);
      pause = idle_len();
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (filtered_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic load_config(input logic en, input logic [COEF_W-1:0] b0, b1, b2, a1, a2);
      quiesce();
      write_csr(CSR_NOTCH_ON, ($urandom() & ~32'd1) | COEF_W'(en));
      write_csr(CSR_COEF_B0, b0);
      write_csr(CSR_COEF_B1, b1);
      write_csr(CSR_COEF_B2, b2);
      write_csr(CSR_COEF_A1, a1);
      write_csr(CSR_COEF_A2, a2);
      csr_valid <= 1'b0;
   endtask

   // mostly whole packets on the grid, some gaps, short, long, stale packets and stray items
   task automatic send_packets(input int n);
      int               target, kind, frames;
      logic [PKT_W-1:0] pkt;
      target = produced + n;
      while (produced < target) begin
         kind   = $urandom_range(0, 99);
         frames = FRAMES;
         pkt    = next_pkt;
         if (kind < 70) begin
            next_pkt++;
         end else if (kind < 80) begin
            next_pkt += $urandom_range(1, 3);
            pkt = next_pkt;
            next_pkt++;
         end else if (kind < 87) begin
            frames = $urandom_range(1, FRAMES - 1);
            next_pkt++;
         end else if (kind < 93) begin
            frames = $urandom_range(FRAMES + 1, FRAMES + 3);
            next_pkt++;
         end else if (kind < 97) begin
            pkt    = next_pkt - $urandom_range(1, 3);
            frames = $urandom_range(1, 5);
         end else begin
            frames = 0;
            send_frame(random_frame($urandom(), 1'b0));
         end
         for (int i = 0; i < frames; i++) begin
            if (i == 0) send_frame(random_frame(pkt, 1'b1));
            else send_frame(random_frame(($urandom_range(0, 3) == 0) ? $urandom() : pkt, 1'b0));
         end
      end
   endtask

   task automatic run_phase(input logic en, input logic [COEF_W-1:0] b0, b1, b2, a1, a2,
         input int n, input logic [CSR_IDX_W-1:0] spare);
      load_config(en, b0, b1, b2, a1, a2);
      send_packets(n / 2);
      quiesce();
      write_csr(spare, $urandom());
      csr_valid <= 1'b0;
      send_packets(n - n / 2);
   endtask

   task automatic test_frames_before_start();
      send_frame(random_frame(32'd9, 1'b0));
      send_frame(random_frame($urandom(), 1'b0));
   endtask

   task automatic test_passthrough_reset_config();
      send_frame(build_frame(32'd3, 1'b1, S_MAX, S_MIN, '0, S_NEG1, 4'b0000));
      send_frame(build_frame(32'd3, 1'b0, S_MIN, '0, S_NEG1, S_MAX, 4'b1111));
      for (int i = 2; i < FRAMES; i++) send_frame(random_frame(32'd3, 1'b0));
   endtask

   task automatic test_notch_saturation();
      load_config(1'b1, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN);
      send_frame(build_frame(32'd4, 1'b1, S_MAX, S_MIN, S_MAX, S_MIN, 4'b0000));
      send_frame(build_frame(32'd4, 1'b0, S_MIN, S_MAX, S_MIN, S_MAX, 4'b1010));
   endtask

   task automatic test_grid_alignment();
      send_frame(build_frame('0, 1'b1, S_MAX, S_MAX, S_MAX, S_MAX, 4'b0101));
      send_frame(random_frame(32'd4, 1'b0));
      send_frame(random_frame(32'd4, 1'b1));
      send_frame(random_frame(32'd4, 1'b0));
      send_frame(random_frame(32'd5, 1'b1));
      send_frame(random_frame(32'd5, 1'b0));
      next_pkt = 32'd6;
   endtask

   task automatic test_random_phases();
      run_phase(1'b1, NOTCH_B0, NOTCH_B1, NOTCH_B0, NOTCH_B1, NOTCH_A2, 140, CSR_SPARE_LO);
      run_phase(1'b0, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), 100,
                CSR_SPARE_HI);
      run_phase(1'b1, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), 140,
                CSR_SPARE_LO);
      run_phase(1'b1, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 90,
                CSR_SPARE_HI);
      run_phase(1'b1, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, 50, CSR_SPARE_LO);
      run_phase(1'b1, '0, '0, '0, '0, '0, 20, CSR_SPARE_HI);
   endtask

   task automatic test_result_backpressure();
      load_config(1'b1, NOTCH_B0, NOTCH_B1, NOTCH_B0, NOTCH_B1, NOTCH_A2);
      steady    = 1'b1;
      sink_hold = 250;
      send_packets(36);
      steady    = 1'b0;
   endtask

   task automatic test_drain_pause();
      send_packets(20);
      quiesce();
      send_packets(20);
   endtask

   task automatic test_gap_saturation();
      send_frame(random_frame(32'hFFFF_FFFF, 1'b1));
      send_frame(random_frame(32'hFFFF_FFFF, 1'b0));
      send_frame(random_frame($urandom(), 1'b0));
      send_frame(random_frame(32'hFFFF_FFFE, 1'b1));
      send_frame(random_frame(32'hFFFF_FFFE, 1'b0));
   endtask

   initial begin : drive_rsp_ready
      int stall;
      forever begin
         @(posedge clock);
         if (sink_hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold) @(posedge clock);
            sink_hold = 0;
            rsp_ready <= 1'b1;
         end else begin
            stall = idle_len();
            if (stall == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      out_frame_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.y[0]   = rsp_filtered_ch0;
         got.y[1]   = rsp_filtered_ch1;
         got.y[2]   = rsp_filtered_ch2;
         got.y[3]   = rsp_filtered_ch3;
         got.absent = rsp_absent_out;
         got.gap    = rsp_gap_before;
         got.grid   = rsp_grid_position;
         if (filtered_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item at %0t, grid %h", $time, got.grid);
         end else begin
            want = filtered_due.pop_front();
            if (got.y[0] !== want.y[0] || got.y[1] !== want.y[1] || got.y[2] !== want.y[2]
                  || got.y[3] !== want.y[3] || got.absent !== want.absent
                  || got.gap !== want.gap || got.grid !== want.grid) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t", $time);
                  $display("  expected %h %h %h %h absent %h gap %h grid %h", want.y[0],
                           want.y[1], want.y[2], want.y[3], want.absent, want.gap, want.grid);
                  $display("  actual   %h %h %h %h absent %h gap %h grid %h", got.y[0],
                           got.y[1], got.y[2], got.y[3], got.absent, got.gap, got.grid);
               end
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_frames_before_start();
      test_passthrough_reset_config();
      test_notch_saturation();
      test_grid_alignment();
      test_random_phases();
      test_result_backpressure();
      test_drain_pause();
      test_gap_saturation();
      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && filtered_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
